// ----- rtl/core/svm_pkg.sv -----
`default_nettype none
package svm_pkg;

  typedef enum logic [4:0] {
    OP_NOP           = 5'd0,
    OP_PUSH          = 5'd1,
    OP_POP           = 5'd2,
    OP_LOCAL_GET     = 5'd3,
    OP_LOCAL_SET     = 5'd4,
    OP_ADD           = 5'd5,
    OP_SUB           = 5'd6,
    OP_MUL           = 5'd7,
    OP_DIV           = 5'd8,
    OP_EQ            = 5'd9,
    OP_LOAD8U        = 5'd10,
    OP_LOAD16U       = 5'd11,
    OP_LT_S          = 5'd12,
    OP_LT_U          = 5'd13,
    OP_LOAD32        = 5'd14,
    OP_JUMP          = 5'd15,
    OP_JZ            = 5'd16,
    OP_JNZ           = 5'd17,
    OP_RETURN        = 5'd18,
    OP_PRINT         = 5'd19,
    OP_PRELOAD_MEM   = 5'd20,
    OP_PRELOAD_LOCAL = 5'd21
  } op_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_RETURNED  = 4'd1,
    ST_PC_RANGE  = 4'd2,
    ST_UNDERFLOW = 4'd3,
    ST_BAD_LOCAL = 4'd4,
    ST_DIV_ZERO  = 4'd5,
    ST_MEM_OOB   = 4'd6,
    ST_BAD_OP    = 4'd7,
    ST_OVERFLOW  = 4'd8,
    ST_NONTERM   = 4'd9,
    ST_STOPPED   = 4'd10
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD_B,
    S_RD_A,
    S_DIV_GO,
    S_DIV,
    S_MEM,
    S_FIN
  } state_t;

  localparam logic [1:0] CFG_CODE_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_LOCALS_COUNT = 2'd1;
  localparam logic [1:0] CFG_MEMORY_SIZE  = 2'd2;

  typedef struct packed {
    logic capture;
    logic rd_top;
    logic rd_second;
    logic latch_b;
    logic latch_a;
    logic rd_local;
    logic div_start;
    logic mem_clr;
    logic mem_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic need_pop;
    logic need_two;
    logic local_rd;
    logic is_load;
    logic is_div;
    logic div_by_zero;
    logic load_oob;
    logic load_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/svm_div.sv -----
`default_nettype none
module svm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  logic [31:0] rem_r, quo_r, dvs_r;
  logic [5:0]  cnt_r;
  logic        neg_r, busy_r;
  logic [32:0] sh, diff;

  assign sh       = {rem_r, quo_r[31]};
  assign diff     = sh - {1'b0, dvs_r};
  assign busy     = busy_r;
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
      rem_r  <= 32'd0;
      quo_r  <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs_r  <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg_r  <= dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      // restoring step: one quotient bit per cycle
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= sh[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
      cnt_r  <= cnt_r - 6'd1;
      busy_r <= (cnt_r != 6'd1);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/svm_ctrl.sv -----
`default_nettype none
module svm_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire svm_pkg::sts_t sts,
  output svm_pkg::cmd_t     cmd
);
  import svm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.skip) begin
          state_nxt = S_FIN;
        end else if (sts.local_rd) begin
          cmd.rd_local = 1'b1;
          state_nxt    = S_FIN;
        end else if (sts.need_pop) begin
          cmd.rd_top = 1'b1;
          state_nxt  = S_RD_B;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RD_B: begin
        cmd.latch_b = 1'b1;
        if (sts.need_two) begin
          cmd.rd_second = 1'b1;
          state_nxt     = S_RD_A;
        end else if (sts.is_load) begin
          cmd.mem_clr = 1'b1;
          state_nxt   = S_MEM;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RD_A: begin
        cmd.latch_a = 1'b1;
        if (sts.is_div && !sts.div_by_zero) state_nxt = S_DIV_GO;
        else                                state_nxt = S_FIN;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_MEM: begin
        if (sts.load_oob || sts.load_done) state_nxt = S_FIN;
        else                               cmd.mem_step = 1'b1;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/svm_dp.sv -----
`default_nettype none
module svm_dp #(
  parameter int STACK_DEPTH  = 256,
  parameter int LOCALS_DEPTH = 256,
  parameter int MEM_DEPTH    = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire svm_pkg::cmd_t cmd,
  output svm_pkg::sts_t      sts,
  input  wire logic [71:0]   in_tdata,
  input  wire logic          cfg_wr,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [63:0]        out_tdata
);
  import svm_pkg::*;

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int LAW = (LOCALS_DEPTH > 1) ? $clog2(LOCALS_DEPTH) : 1;
  localparam int MAW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [15:0]    code_len_r;
  logic [8:0]     loc_cnt_r;
  logic [12:0]    mem_size_r;
  logic [4:0]     op_r;
  logic [31:0]    imm_r;
  logic [15:0]    ipc_r;
  logic [11:0]    paddr_r;
  logic [31:0]    a_r, b_r, ld_r;
  logic [SCW-1:0] cnt_r;
  logic           stopped_r;
  logic [2:0]     k_r;
  logic           out_valid_r;
  logic [63:0]    out_data_r;

  logic [31:0] stk_mem [STACK_DEPTH];
  logic [31:0] loc_mem [LOCALS_DEPTH];
  logic [7:0]  dat_mem [MEM_DEPTH];
  logic [31:0] stk_rd_r, loc_rd_r;
  logic [7:0]  dat_rd_r;

  logic           div_busy;
  logic [31:0]    div_q;

  logic [31:0]    lcount, paddr32;
  logic [32:0]    msize, last_addr, rd_addr33;
  logic           has_imm, pre_mem, pre_loc, is_jump, take, tgt_bad;
  logic [16:0]    nxt, npc17;
  logic [33:0]    tgt;
  logic [2:0]     ld_n;
  status_t        early_err, late_err, err, st;
  logic [1:0]     pops;
  logic           push, commit, ret;
  logic [SCW-1:0] base, stk_rd_cnt;
  logic [31:0]    push_val, rv;
  logic           pv;
  logic [7:0]     pb;
  logic [1:0]     kk;

  svm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (a_r),
    .divisor  (b_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    lcount  = (32'(loc_cnt_r) < 32'(LOCALS_DEPTH)) ? 32'(loc_cnt_r) : 32'(LOCALS_DEPTH);
    msize   = (33'(mem_size_r) < 33'(MEM_DEPTH)) ? 33'(mem_size_r) : 33'(MEM_DEPTH);
    paddr32 = {20'd0, paddr_r};
    has_imm = op_r inside {OP_PUSH, OP_LOCAL_GET, OP_LOCAL_SET, OP_JUMP, OP_JZ, OP_JNZ};
    nxt     = 17'(ipc_r) + (has_imm ? 17'd5 : 17'd1);
    pre_mem = (op_r == OP_PRELOAD_MEM);
    pre_loc = (op_r == OP_PRELOAD_LOCAL);
    is_jump = op_r inside {OP_JUMP, OP_JZ, OP_JNZ};

    case (op_r)
      OP_LOAD8U:  ld_n = 3'd1;
      OP_LOAD16U: ld_n = 3'd2;
      default:    ld_n = 3'd4;
    endcase
    last_addr = {1'b0, b_r} + 33'(ld_n - 3'd1);
    rd_addr33 = {1'b0, b_r} + 33'(k_r);
    kk        = 2'(k_r - 3'd1);

    pops = 2'd0;
    push = 1'b0;
    case (op_r)
      OP_PUSH, OP_LOCAL_GET:               push = 1'b1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT_S, OP_LT_U: begin
        pops = 2'd2;
        push = 1'b1;
      end
      OP_LOAD8U, OP_LOAD16U, OP_LOAD32: begin
        pops = 2'd1;
        push = 1'b1;
      end
      OP_POP, OP_LOCAL_SET, OP_JZ, OP_JNZ, OP_RETURN, OP_PRINT: pops = 2'd1;
      default: ;
    endcase

    early_err = ST_OK;
    if (17'(ipc_r) >= 17'(code_len_r) || (has_imm && nxt > 17'(code_len_r))) begin
      early_err = ST_PC_RANGE;
    end else begin
      case (op_r)
        OP_NOP, OP_JUMP: ;
        OP_PUSH:
          if (cnt_r == SCW'(STACK_DEPTH)) early_err = ST_OVERFLOW;
        OP_LOCAL_GET:
          if (imm_r >= lcount)                 early_err = ST_BAD_LOCAL;
          else if (cnt_r == SCW'(STACK_DEPTH)) early_err = ST_OVERFLOW;
        OP_LOCAL_SET:
          if (imm_r >= lcount)    early_err = ST_BAD_LOCAL;
          else if (cnt_r == '0)   early_err = ST_UNDERFLOW;
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT_S, OP_LT_U:
          if (cnt_r < SCW'(2)) early_err = ST_UNDERFLOW;
        OP_POP, OP_LOAD8U, OP_LOAD16U, OP_LOAD32, OP_JZ, OP_JNZ, OP_RETURN, OP_PRINT:
          if (cnt_r == '0) early_err = ST_UNDERFLOW;
        default: early_err = ST_BAD_OP;
      endcase
    end

    tgt     = 34'(ipc_r) + {{2{imm_r[31]}}, imm_r};
    tgt_bad = tgt[33] || (tgt > 34'(code_len_r));
    case (op_r)
      OP_JZ:   take = (b_r == 32'd0);
      OP_JNZ:  take = (b_r != 32'd0);
      default: take = 1'b1;
    endcase

    late_err = ST_OK;
    if (op_r == OP_DIV && b_r == 32'd0)                                 late_err = ST_DIV_ZERO;
    else if ((op_r inside {OP_LOAD8U, OP_LOAD16U, OP_LOAD32}) && last_addr >= msize)
      late_err = ST_MEM_OOB;
    else if (is_jump && take && tgt_bad)                                late_err = ST_PC_RANGE;
    err = (early_err != ST_OK) ? early_err : late_err;

    case (op_r)
      OP_PUSH:      push_val = imm_r;
      OP_LOCAL_GET: push_val = loc_rd_r;
      OP_ADD:       push_val = a_r + b_r;
      OP_SUB:       push_val = a_r - b_r;
      OP_MUL:       push_val = a_r * b_r;
      OP_DIV:       push_val = div_q;
      OP_EQ:        push_val = {31'd0, a_r == b_r};
      OP_LT_S:      push_val = {31'd0, $signed(a_r) < $signed(b_r)};
      OP_LT_U:      push_val = {31'd0, a_r < b_r};
      default:      push_val = ld_r;
    endcase

    ret    = (op_r == OP_RETURN);
    npc17  = (is_jump && take) ? tgt[16:0] : nxt;
    commit = !stopped_r && !pre_mem && !pre_loc && err == ST_OK;
    st = ST_OK;
    rv = 32'd0;
    pv = 1'b0;
    pb = 8'd0;
    if (stopped_r) begin
      st = ST_STOPPED;
    end else if (pre_mem || pre_loc) begin
      st = ST_OK;
    end else if (err != ST_OK) begin
      st = err;
    end else if (ret) begin
      st = ST_RETURNED;
      rv = b_r;
    end else begin
      st = (npc17 >= 17'(code_len_r)) ? ST_NONTERM : ST_OK;
      pv = (op_r == OP_PRINT);
      pb = pv ? b_r[7:0] : 8'd0;
    end

    base       = cnt_r - SCW'(pops);
    stk_rd_cnt = cmd.rd_second ? (cnt_r - SCW'(2)) : (cnt_r - SCW'(1));

    sts.skip        = stopped_r || pre_mem || pre_loc || early_err != ST_OK;
    sts.need_pop    = (pops != 2'd0);
    sts.need_two    = (pops == 2'd2);
    sts.local_rd    = (op_r == OP_LOCAL_GET);
    sts.is_load     = op_r inside {OP_LOAD8U, OP_LOAD16U, OP_LOAD32};
    sts.is_div      = (op_r == OP_DIV);
    sts.div_by_zero = (b_r == 32'd0);
    sts.load_oob    = (last_addr >= msize);
    sts.load_done   = (k_r == ld_n + 3'd1);
    sts.div_done    = !div_busy;
    sts.out_free    = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_len_r  <= 16'd0;
      loc_cnt_r   <= 9'd0;
      mem_size_r  <= 13'd0;
      cnt_r       <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= 3'd0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_CODE_LENGTH:  code_len_r <= cfg_data;
          CFG_LOCALS_COUNT: loc_cnt_r  <= cfg_data[8:0];
          CFG_MEMORY_SIZE:  mem_size_r <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (cmd.mem_clr)       k_r <= 3'd0;
      else if (cmd.mem_step) k_r <= k_r + 3'd1;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (commit) cnt_r <= base + SCW'(push);
        if (!stopped_r && !pre_mem && !pre_loc && (err != ST_OK || ret || st == ST_NONTERM))
          stopped_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_tdata[4:0];
      imm_r   <= in_tdata[36:5];
      ipc_r   <= in_tdata[52:37];
      paddr_r <= in_tdata[64:53];
    end
    if (cmd.latch_b) b_r <= stk_rd_r;
    if (cmd.latch_a) a_r <= stk_rd_r;
    if (cmd.mem_clr) ld_r <= 32'd0;
    else if (cmd.mem_step && k_r != 3'd0) ld_r[8*kk +: 8] <= dat_rd_r;
    if (cmd.finish) begin
      out_data_r <= {3'd0, pb, pv, rv, (st == ST_OK || st == ST_NONTERM || st == ST_RETURNED)
                     && !stopped_r && !pre_mem && !pre_loc ? npc17[15:0] : ipc_r, st};
    end
  end

  // operand stack: one read port, one write port
  always_ff @(posedge clk) begin
    if (cmd.rd_top || cmd.rd_second) stk_rd_r <= stk_mem[stk_rd_cnt[SAW-1:0]];
    if (cmd.finish && commit && push) stk_mem[base[SAW-1:0]] <= push_val;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_local) loc_rd_r <= loc_mem[imm_r[LAW-1:0]];
    if (cmd.finish && commit && op_r == OP_LOCAL_SET) loc_mem[imm_r[LAW-1:0]] <= b_r;
    else if (cmd.finish && !stopped_r && pre_loc && paddr32 < 32'(LOCALS_DEPTH))
      loc_mem[paddr32[LAW-1:0]] <= imm_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_step && k_r < ld_n) dat_rd_r <= dat_mem[rd_addr33[MAW-1:0]];
    if (cmd.finish && !stopped_r && pre_mem && paddr32 < 32'(MEM_DEPTH))
      dat_mem[paddr32[MAW-1:0]] <= imm_r[7:0];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SCW'(STACK_DEPTH))
    else $error("stack count above depth");
  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped flag cleared without reset");
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("result overwrote pending transaction");
  a_stop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && stopped_r) |=> (out_data_r[3:0] == ST_STOPPED))
    else $error("stopped block reported wrong status");
endmodule
`default_nettype wire

// ----- rtl/core/stack_vm_execute_unit.sv -----
// Items pass S_IDLE, S_CHECK and S_FIN; pops read the stack in S_RD_B, and in S_RD_A for
// two entries (one operand stack read port, one entry per cycle); loads step through S_MEM
// one byte per cycle, with no byte read when out of bounds; division waits in S_DIV for the
// radix-2 divider. One item is handled at a time; a new item is taken while a result waits
// in the output register. Reset (rst_n low, synchronous) clears stack count, stopped flag,
// configuration and handshake state; memories are kept.
`default_nettype none
module stack_vm_execute_unit #(
  parameter int STACK_DEPTH  = 256,
  parameter int LOCALS_DEPTH = 256,
  parameter int MEM_DEPTH    = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // op[4:0], immediate[36:5], instr_pc[52:37], preload_address[64:53], zero pad
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[3:0], next_pc[19:4], ret_val[51:20], print_valid[52], print_byte[60:53]
  output logic [63:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import svm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  svm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  svm_dp #(
    .STACK_DEPTH  (STACK_DEPTH),
    .LOCALS_DEPTH (LOCALS_DEPTH),
    .MEM_DEPTH    (MEM_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_wr     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );
endmodule
`default_nettype wire
